/* rtl/core/rpt_pkg.sv */
// ----------------------------------------------------------------------------
// rpt_pkg
// Types, token codes and character constants shared by the regex pattern
// tokenizer modules.
// ----------------------------------------------------------------------------
package rpt_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX1   = 2'd2,
    MODE_HEX2   = 2'd3
  } lex_mode_e;

  typedef enum logic [4:0] {
    TT_END     = 5'd0,
    TT_LPAREN  = 5'd1,
    TT_RPAREN  = 5'd2,
    TT_LCURLY  = 5'd3,
    TT_RCURLY  = 5'd4,
    TT_STAR    = 5'd5,
    TT_PLUS    = 5'd6,
    TT_UNION   = 5'd7,
    TT_QMARK   = 5'd8,
    TT_DOT     = 5'd9,
    TT_DIGIT   = 5'd10,
    TT_CHAR    = 5'd11,
    TT_NOTHING = 5'd12,
    TT_EMPTY   = 5'd13,
    TT_DCLASS  = 5'd14,
    TT_SCLASS  = 5'd15,
    TT_WCLASS  = 5'd16
  } token_type_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_PREMATURE = 2'd1,
    ERR_ESCAPE    = 2'd2,
    ERR_HEX       = 2'd3
  } lex_error_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } pattern_item_t;

  typedef struct packed {
    logic [4:0] token_type;
    logic [7:0] token_char;
    logic [1:0] error;
  } token_t;

  // Character codes.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_UNION  = 8'h7C;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_W = 8'h77;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // Control characters produced by the named escapes.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Bit 4 set means the character is not a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = {1'b0, 4'(c - CH_ZERO)};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

/* rtl/core/regex_pattern_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// regex_pattern_tokenizer_top
// Streaming tokenizer for regular expression patterns.
// ----------------------------------------------------------------------------
// Pattern bytes enter one per request, followed by an end-of-pattern request;
// each completed symbol leaves as one token request with its type, character
// and error code, while a backslash, a \x or a first hex digit produce none.
// A request is registered at the input, decoded from it against the
// escape/hex mode, and its token is registered at the output; the block
// sustains one pattern byte per cycle while the output is not stalled. The
// only loop is the update of the lexer mode and hex nibble; a stall on the
// output side holds the input register and backs up onto in_stall_o.
module regex_pattern_tokenizer_top import rpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pattern_item_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output token_t        out_token_o
);

  logic          in_valid_q;
  pattern_item_t in_item_q;
  logic          out_valid_q;
  token_t        out_token_q;

  logic          res_valid;
  token_t        res_token;
  logic          out_free;
  logic          advance;
  logic          in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  // Requests that yield no token can move on even while the output is full.
  assign advance    = in_valid_q && (out_free || !res_valid);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  rpt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .token_o     (res_token)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_token_q <= res_token;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_token_o = out_token_q;

endmodule

/* rtl/core/rpt_lexer.sv */
// ----------------------------------------------------------------------------
// rpt_lexer
// Lexer state (escape/hex mode and high nibble) and the one-step decode
// that turns a pattern item into zero or one token.
// ----------------------------------------------------------------------------
module rpt_lexer import rpt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  pattern_item_t item_i,
  output logic          res_valid_o,
  output token_t        token_o
);

  lex_mode_e  mode_q, mode_d;
  logic [3:0] nibble_q, nibble_d;
  logic [4:0] hv;
  logic [7:0] c;

  assign c  = item_i.byte_value;
  assign hv = hex_value(c);

  always_comb begin
    mode_d      = mode_q;
    nibble_d    = nibble_q;
    res_valid_o = 1'b0;
    token_o     = '{token_type: TT_END, token_char: 8'd0, error: ERR_NONE};

    if (item_i.kind == KIND_END) begin
      res_valid_o = 1'b1;
      if (mode_q != MODE_NORMAL) begin
        token_o.error = ERR_PREMATURE;
      end
      mode_d = MODE_NORMAL;
    end else begin
      unique case (mode_q)
        MODE_NORMAL: begin
          res_valid_o = 1'b1;
          unique case (c)
            CH_LPAREN: token_o.token_type = TT_LPAREN;
            CH_RPAREN: token_o.token_type = TT_RPAREN;
            CH_LCURLY: token_o.token_type = TT_LCURLY;
            CH_RCURLY: token_o.token_type = TT_RCURLY;
            CH_STAR:   token_o.token_type = TT_STAR;
            CH_PLUS:   token_o.token_type = TT_PLUS;
            CH_UNION:  token_o.token_type = TT_UNION;
            CH_QMARK:  token_o.token_type = TT_QMARK;
            CH_DOT:    token_o.token_type = TT_DOT;
            CH_BSLASH: begin
              res_valid_o = 1'b0;
              mode_d      = MODE_ESC;
            end
            default: begin
              token_o.token_char = c;
              if (c >= CH_ZERO && c <= CH_NINE) begin
                token_o.token_type = TT_DIGIT;
              end else begin
                token_o.token_type = TT_CHAR;
              end
            end
          endcase
        end
        MODE_ESC: begin
          mode_d      = MODE_NORMAL;
          res_valid_o = 1'b1;
          unique case (c)
            CH_HASH:    token_o.token_type = TT_NOTHING;
            CH_LOWER_E: token_o.token_type = TT_EMPTY;
            CH_LOWER_N: token_o = '{token_type: TT_CHAR, token_char: CH_LF, error: ERR_NONE};
            CH_LOWER_R: token_o = '{token_type: TT_CHAR, token_char: CH_CR, error: ERR_NONE};
            CH_LOWER_F: token_o = '{token_type: TT_CHAR, token_char: CH_FF, error: ERR_NONE};
            CH_LOWER_T: token_o = '{token_type: TT_CHAR, token_char: CH_TAB, error: ERR_NONE};
            CH_BSLASH, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS,
            CH_UNION, CH_QMARK, CH_LCURLY, CH_RCURLY, CH_DOT: begin
              token_o.token_type = TT_CHAR;
              token_o.token_char = c;
            end
            CH_LOWER_D: token_o.token_type = TT_DCLASS;
            CH_LOWER_S: token_o.token_type = TT_SCLASS;
            CH_LOWER_W: token_o.token_type = TT_WCLASS;
            CH_LOWER_X: begin
              res_valid_o = 1'b0;
              mode_d      = MODE_HEX1;
            end
            default: token_o.error = ERR_ESCAPE;
          endcase
        end
        MODE_HEX1: begin
          if (hv[4]) begin
            res_valid_o   = 1'b1;
            token_o.error = ERR_HEX;
            mode_d        = MODE_NORMAL;
          end else begin
            nibble_d = hv[3:0];
            mode_d   = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          mode_d      = MODE_NORMAL;
          res_valid_o = 1'b1;
          if (hv[4]) begin
            token_o.error = ERR_HEX;
          end else begin
            token_o.token_type = TT_CHAR;
            token_o.token_char = {nibble_q, hv[3:0]};
          end
        end
        default: mode_d = MODE_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NORMAL;
      nibble_q <= 4'd0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      nibble_q <= nibble_d;
    end
  end

endmodule
